>>> design/srtf_pkg.sv
// shared types and constants for the srtf tick scheduler
// no dependencies; imported by srtf_cell and srtf_tick_scheduler_unit
`default_nettype none

package srtf_pkg;

  // defaults for the top level parameters
  localparam int MAX_PROCS_DEF  = 16;
  localparam int TIME_WIDTH_DEF = 16;

  // widths fixed by the port list
  localparam int PORT_TIME_W  = 16;
  localparam int PORT_LABEL_W = 5;

  // input function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } srtf_state_t;

  // per-cell strobes from the sequencer
  typedef struct packed {
    logic ld_en;
    logic upd_en;
  } srtf_cell_ctl_t;

endpackage

`default_nettype wire

>>> design/srtf_cell.sv
// one process slot of the scheduler row plus one stage of the winner chain
// depends on srtf_pkg (cell control struct)
`default_nettype none

module srtf_cell #(
  parameter int TW    = 16,
  parameter int LBLW  = 5,
  parameter int LABEL = 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  srtf_pkg::srtf_cell_ctl_t ctl,
  input  logic [TW-1:0]           ld_arr,
  input  logic [TW-1:0]           ld_bur,
  input  logic [TW-1:0]           cur_time,
  input  logic                    tin_found,
  input  logic [TW-1:0]           tin_rem,
  input  logic [TW-1:0]           tin_arr,
  input  logic [TW-1:0]           tin_bur,
  input  logic [LBLW-1:0]         tin_lbl,
  input  logic [LBLW-1:0]         tin_cnt,
  output logic                    tout_found,
  output logic [TW-1:0]           tout_rem,
  output logic [TW-1:0]           tout_arr,
  output logic [TW-1:0]           tout_bur,
  output logic [LBLW-1:0]         tout_lbl,
  output logic [LBLW-1:0]         tout_cnt
);
  import srtf_pkg::*;

  logic            valid_r;
  logic            fin_r;
  logic [TW-1:0]   arr_r;
  logic [TW-1:0]   bur_r;
  logic [TW-1:0]   rem_r;

  logic            found_r;
  logic [TW-1:0]   t_rem_r;
  logic [TW-1:0]   t_arr_r;
  logic [TW-1:0]   t_bur_r;
  logic [LBLW-1:0] t_lbl_r;
  logic [LBLW-1:0] t_cnt_r;

  logic mine;
  logic elig;
  logic better;

  assign mine   = valid_r & ~fin_r;
  assign elig   = mine & (arr_r <= cur_time);
  // strictly better only, so ties keep the earlier label
  assign better = elig & (~tin_found | (rem_r < tin_rem) |
                          ((rem_r == tin_rem) & (arr_r < tin_arr)));

  // slot state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      fin_r   <= 1'b0;
    end else if (ctl.ld_en) begin
      valid_r <= 1'b1;
      fin_r   <= 1'b0;
    end else if (ctl.upd_en) begin
      if (rem_r == TW'(1)) begin
        fin_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_en) begin
      arr_r <= ld_arr;
      bur_r <= ld_bur;
      rem_r <= ld_bur;
    end else if (ctl.upd_en) begin
      rem_r <= rem_r - TW'(1);
    end
  end

  // chain stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      t_cnt_r <= '0;
    end else begin
      found_r <= tin_found | elig;
      t_cnt_r <= tin_cnt + LBLW'(mine);
    end
  end

  always_ff @(posedge clk) begin
    if (better) begin
      t_rem_r <= rem_r;
      t_arr_r <= arr_r;
      t_bur_r <= bur_r;
      t_lbl_r <= LBLW'(LABEL);
    end else begin
      t_rem_r <= tin_rem;
      t_arr_r <= tin_arr;
      t_bur_r <= tin_bur;
      t_lbl_r <= tin_lbl;
    end
  end

  assign tout_found = found_r;
  assign tout_rem   = t_rem_r;
  assign tout_arr   = t_arr_r;
  assign tout_bur   = t_bur_r;
  assign tout_lbl   = t_lbl_r;
  assign tout_cnt   = t_cnt_r;

endmodule

`default_nettype wire

>>> design/srtf_tick_scheduler_unit.sv
// top level of the shortest-remaining-time-first tick scheduler
// depends on srtf_pkg and srtf_cell
//
//   channel | direction | beat contents                                   | handshake
//   in_     | input     | func, arrival_time, burst_time                  | in_valid / in_stall
//   out_    | output    | slot_start, running_label, finished,
//           |           | completion_time, turnaround, waiting, all_done  | out_valid / out_stall
//
// a load beat gives no result
// a tick beat is taken in the idle state; the scan state then lets the winner token ripple
//   down the row of cells, and the update state updates the winner and registers the
//   result in the output register
// the update state waits while the output register is full and stalled
// rst_n is synchronous; it empties the table, clears time and drops out_valid
// the next input beat is taken while a result still waits at the output
`default_nettype none

module srtf_tick_scheduler_unit #(
  parameter int MAX_PROCS  = srtf_pkg::MAX_PROCS_DEF,
  parameter int TIME_WIDTH = srtf_pkg::TIME_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_func,
  input  logic [srtf_pkg::PORT_TIME_W-1:0]   in_arrival_time,
  input  logic [srtf_pkg::PORT_TIME_W-1:0]   in_burst_time,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [srtf_pkg::PORT_TIME_W-1:0]   out_slot_start,
  output logic [srtf_pkg::PORT_LABEL_W-1:0]  out_running_label,
  output logic                               out_finished,
  output logic [srtf_pkg::PORT_TIME_W-1:0]   out_completion_time,
  output logic [srtf_pkg::PORT_TIME_W-1:0]   out_turnaround,
  output logic [srtf_pkg::PORT_TIME_W-1:0]   out_waiting,
  output logic                               out_all_done
);
  import srtf_pkg::*;

  localparam int TW   = TIME_WIDTH;
  localparam int N    = MAX_PROCS;
  localparam int LBLW = $clog2(N + 1);          // labels 0..N and counts 0..N
  localparam int CW   = (N > 1) ? $clog2(N) : 1; // scan cycle counter
  localparam logic [31:0]   TMAX32 = 32'((64'd1 << TW) - 64'd1);
  localparam logic [TW-1:0] TMAX   = TMAX32[TW-1:0];

  // sequencer
  srtf_state_t     state_r, state_nxt;
  logic [CW-1:0]   scan_cnt_r, scan_cnt_nxt;
  logic [LBLW-1:0] loaded_cnt_r;
  logic [TW-1:0]   cur_time_r;
  logic            out_valid_r;

  logic in_fire;
  logic ld_fire;
  logic upd_fire;
  logic scan_last;

  // load data, saturated to the time range
  logic [31:0]   arr32, bur32;
  logic [TW-1:0] ld_arr, ld_bur;

  assign arr32  = 32'(in_arrival_time);
  assign bur32  = 32'(in_burst_time);
  assign ld_arr = (arr32 > TMAX32) ? TMAX : arr32[TW-1:0];
  assign ld_bur = (bur32 > TMAX32) ? TMAX : bur32[TW-1:0];

  assign in_fire   = in_valid & ~in_stall;
  // table full or zero burst drops the load silently
  assign ld_fire   = in_fire & (in_func == FUNC_LOAD) &
                     (loaded_cnt_r < LBLW'(N)) & (ld_bur != '0);
  assign scan_last = (scan_cnt_r == CW'(N - 1));

  // winner chain: entry 0 is an empty token, entry N is the tail
  logic            t_found [0:N];
  logic [TW-1:0]   t_rem   [0:N];
  logic [TW-1:0]   t_arr   [0:N];
  logic [TW-1:0]   t_bur   [0:N];
  logic [LBLW-1:0] t_lbl   [0:N];
  logic [LBLW-1:0] t_cnt   [0:N];

  assign t_found[0] = 1'b0;
  assign t_rem[0]   = '0;
  assign t_arr[0]   = '0;
  assign t_bur[0]   = '0;
  assign t_lbl[0]   = '0;
  assign t_cnt[0]   = '0;

  srtf_cell_ctl_t cell_ctl [0:N-1];

  for (genvar i = 0; i < N; i++) begin : g_cell
    // loads go to the next free slot, updates to the slot that won the scan
    assign cell_ctl[i].ld_en  = ld_fire & (loaded_cnt_r == LBLW'(i));
    assign cell_ctl[i].upd_en = upd_fire & t_found[N] & (t_lbl[N] == LBLW'(i + 1));

    srtf_cell #(
      .TW    (TW),
      .LBLW  (LBLW),
      .LABEL (i + 1)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (cell_ctl[i]),
      .ld_arr     (ld_arr),
      .ld_bur     (ld_bur),
      .cur_time   (cur_time_r),
      .tin_found  (t_found[i]),
      .tin_rem    (t_rem[i]),
      .tin_arr    (t_arr[i]),
      .tin_bur    (t_bur[i]),
      .tin_lbl    (t_lbl[i]),
      .tin_cnt    (t_cnt[i]),
      .tout_found (t_found[i+1]),
      .tout_rem   (t_rem[i+1]),
      .tout_arr   (t_arr[i+1]),
      .tout_bur   (t_bur[i+1]),
      .tout_lbl   (t_lbl[i+1]),
      .tout_cnt   (t_cnt[i+1])
    );
  end

  // next state
  always_comb begin
    state_nxt    = state_r;
    scan_cnt_nxt = scan_cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        scan_cnt_nxt = '0;
        if (in_fire && (in_func == FUNC_TICK)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + CW'(1);
        if (scan_last) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (upd_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    upd_fire = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_stall = 1'b0;
      ST_SCAN:   in_stall = 1'b1;
      ST_UPDATE: upd_fire = ~(out_valid_r & out_stall);
      default:   in_stall = 1'b1;
    endcase
  end

  // slot results from the tail token
  logic            fin;
  logic [TW-1:0]   time_inc;
  logic [TW-1:0]   comp, tat, wait_t;
  logic [LBLW-1:0] left_cnt;
  logic [LBLW-1:0] label;
  logic            all_done;

  assign time_inc = (cur_time_r == TMAX) ? TMAX : cur_time_r + TW'(1);
  assign fin      = t_found[N] & (t_rem[N] == TW'(1));
  assign comp     = fin ? time_inc : '0;
  assign tat      = fin ? (time_inc - t_arr[N]) : '0;
  // saturated time can leave turnaround short of the burst
  assign wait_t   = (fin && (tat >= t_bur[N])) ? (tat - t_bur[N]) : '0;
  assign left_cnt = t_cnt[N] - LBLW'(fin);
  assign all_done = (left_cnt == '0);
  assign label    = t_found[N] ? t_lbl[N] : '0;

  logic [31:0] start32, comp32, tat32, wait32, label32;
  assign start32 = 32'(cur_time_r);
  assign comp32  = 32'(comp);
  assign tat32   = 32'(tat);
  assign wait32  = 32'(wait_t);
  assign label32 = 32'(label);

  // output register
  logic [PORT_TIME_W-1:0]  out_start_r, out_comp_r, out_tat_r, out_wait_r;
  logic [PORT_LABEL_W-1:0] out_label_r;
  logic                    out_fin_r, out_all_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      scan_cnt_r   <= '0;
      loaded_cnt_r <= '0;
      cur_time_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_cnt_r <= scan_cnt_nxt;
      if (ld_fire) begin
        loaded_cnt_r <= loaded_cnt_r + LBLW'(1);
      end
      if (upd_fire) begin
        cur_time_r  <= time_inc;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      out_start_r <= start32[PORT_TIME_W-1:0];
      out_label_r <= label32[PORT_LABEL_W-1:0];
      out_fin_r   <= fin;
      out_comp_r  <= comp32[PORT_TIME_W-1:0];
      out_tat_r   <= tat32[PORT_TIME_W-1:0];
      out_wait_r  <= wait32[PORT_TIME_W-1:0];
      out_all_r   <= all_done;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_slot_start      = out_start_r;
  assign out_running_label   = out_label_r;
  assign out_finished        = out_fin_r;
  assign out_completion_time = out_comp_r;
  assign out_turnaround      = out_tat_r;
  assign out_waiting         = out_wait_r;
  assign out_all_done        = out_all_r;

  // checks
  a_out_from_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_UPDATE))
    else $error("result appeared outside the update cycle");

  a_time_stable_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |=> $stable(cur_time_r) && $stable(loaded_cnt_r))
    else $error("time or table size moved during a scan");

  a_winner_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE && t_found[N]) |->
      (t_lbl[N] != '0 && t_lbl[N] <= loaded_cnt_r && t_cnt[N] != '0))
    else $error("winner label outside the loaded table");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE) |-> (t_cnt[N] <= loaded_cnt_r && loaded_cnt_r <= LBLW'(N)))
    else $error("unfinished count exceeds loaded count");

endmodule

`default_nettype wire

>>> sim/tb_srtf_tick_scheduler_unit.sv
// self-checking testbench for srtf_tick_scheduler_unit: directed table and random traffic,
// checked against hand-written results in typed rows and an in-bench predictor
// depends on srtf_pkg and the design sources of srtf_tick_scheduler_unit
`timescale 1ns / 100ps

module tb_srtf_tick_scheduler_unit;
  import srtf_pkg::*;

  // predictor sizing follows the block's default parameters
  localparam int          TABLE_DEPTH  = MAX_PROCS_DEF;
  localparam int          TIME_W       = TIME_WIDTH_DEF;
  localparam int unsigned TIME_LIMIT   = (64'd1 << TIME_W) - 1;
  localparam int          RANDOM_BEATS = 670;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          MAX_REPORTS  = 40;

  // receiver stall behavior
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PATTERN
  } stall_style_t;

  // one result beat, laid out as on the out_ port
  typedef struct packed {
    logic [PORT_TIME_W-1:0]  slot_start;
    logic [PORT_LABEL_W-1:0] label;
    logic                    finished;
    logic [PORT_TIME_W-1:0]  completion;
    logic [PORT_TIME_W-1:0]  turnaround;
    logic [PORT_TIME_W-1:0]  waiting;
    logic                    all_done;
  } slot_report_t;

  // one row of the directed table; typed rows carry a hand-written result
  typedef struct {
    logic                   func;
    logic [PORT_TIME_W-1:0] arrival;
    logic [PORT_TIME_W-1:0] burst;
    bit                     typed;
    slot_report_t           typed_slot;
  } directed_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_func;
  logic [PORT_TIME_W-1:0]  in_arrival_time;
  logic [PORT_TIME_W-1:0]  in_burst_time;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [PORT_TIME_W-1:0]  out_slot_start;
  logic [PORT_LABEL_W-1:0] out_running_label;
  logic                    out_finished;
  logic [PORT_TIME_W-1:0]  out_completion_time;
  logic [PORT_TIME_W-1:0]  out_turnaround;
  logic [PORT_TIME_W-1:0]  out_waiting;
  logic                    out_all_done;

  srtf_tick_scheduler_unit uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_func             (in_func),
    .in_arrival_time     (in_arrival_time),
    .in_burst_time       (in_burst_time),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_slot_start      (out_slot_start),
    .out_running_label   (out_running_label),
    .out_finished        (out_finished),
    .out_completion_time (out_completion_time),
    .out_turnaround      (out_turnaround),
    .out_waiting         (out_waiting),
    .out_all_done        (out_all_done)
  );

  always #2 clk = ~clk;

  // hard stop, far beyond the slowest legal run (fewer than a thousand beats, well under a
  // millisecond)
  initial begin
    #(4_000_000);
    $display("[srtf_tick_scheduler_unit] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // scheduler predictor: process table, finish marks, table fill and the clock
  // ---------------------------------------------------------------------------
  int unsigned arrival_tbl [TABLE_DEPTH];
  int unsigned burst_tbl   [TABLE_DEPTH];
  int unsigned remain_tbl  [TABLE_DEPTH];
  bit          done_tbl    [TABLE_DEPTH];
  int unsigned proc_count;
  int unsigned clock_now;

  // expected result beats, oldest first
  slot_report_t pending_slots[$];

  // run bookkeeping
  int           err_count     = 0;
  int           ticks_sent    = 0;
  int           loads_taken   = 0;
  int           loads_dropped = 0;
  int           finishes_seen = 0;
  int           burst_left    = 0;
  bit           gaps_on       = 1'b1;
  stall_style_t stall_style   = STALL_NONE;
  int unsigned  stall_phase   = 0;
  slot_report_t head_slot;

  function automatic int unsigned clip_to_time(longint unsigned v);
    return (v > TIME_LIMIT) ? TIME_LIMIT : v[31:0];
  endfunction

  // append a process; full table or zero burst leaves the table untouched
  function automatic bit store_process(logic [PORT_TIME_W-1:0] a, logic [PORT_TIME_W-1:0] b);
    int unsigned a_t;
    int unsigned b_t;
    a_t = clip_to_time(a);
    b_t = clip_to_time(b);
    if (proc_count >= TABLE_DEPTH || b_t == 0) return 1'b0;
    arrival_tbl[proc_count] = a_t;
    burst_tbl[proc_count]   = b_t;
    remain_tbl[proc_count]  = b_t;
    done_tbl[proc_count]    = 1'b0;
    proc_count++;
    return 1'b1;
  endfunction

  // one time unit: least remaining time among arrived, unfinished processes;
  // ties to the earlier arrival, then to the lower label (scan order)
  function automatic slot_report_t run_slot();
    slot_report_t r;
    int unsigned  start;
    int unsigned  fin_at;
    int unsigned  tat;
    int           pick;
    bit           found;
    bit           all_clear;
    r         = '0;
    start     = clock_now;
    pick      = 0;
    found     = 1'b0;
    all_clear = 1'b1;
    for (int i = 0; i < proc_count; i++) begin
      if (!done_tbl[i] && arrival_tbl[i] <= start) begin
        if (!found || remain_tbl[i] < remain_tbl[pick] ||
            (remain_tbl[i] == remain_tbl[pick] && arrival_tbl[i] < arrival_tbl[pick])) begin
          pick  = i;
          found = 1'b1;
        end
      end
    end
    r.slot_start = start[PORT_TIME_W-1:0];
    if (found) begin
      r.label = PORT_LABEL_W'(pick + 1);
      if (remain_tbl[pick] > 0) remain_tbl[pick]--;
      if (remain_tbl[pick] == 0) begin
        done_tbl[pick] = 1'b1;
        fin_at         = clip_to_time(longint'(start) + 1);
        tat            = fin_at - arrival_tbl[pick];
        r.finished     = 1'b1;
        r.completion   = fin_at[PORT_TIME_W-1:0];
        r.turnaround   = tat[PORT_TIME_W-1:0];
        // slots stacked at the saturated time can leave turnaround below the burst
        r.waiting      = (tat >= burst_tbl[pick]) ? PORT_TIME_W'(tat - burst_tbl[pick]) : '0;
      end
    end
    for (int i = 0; i < proc_count; i++)
      if (!done_tbl[i]) all_clear = 1'b0;
    r.all_done = all_clear;
    clock_now  = clip_to_time(longint'(start) + 1);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // directed table helpers
  // ---------------------------------------------------------------------------
  function automatic slot_report_t slot_of(int unsigned s, int unsigned l, bit f,
                                           int unsigned c, int unsigned t, int unsigned w,
                                           bit d);
    slot_report_t r;
    r.slot_start = s[PORT_TIME_W-1:0];
    r.label      = l[PORT_LABEL_W-1:0];
    r.finished   = f;
    r.completion = c[PORT_TIME_W-1:0];
    r.turnaround = t[PORT_TIME_W-1:0];
    r.waiting    = w[PORT_TIME_W-1:0];
    r.all_done   = d;
    return r;
  endfunction

  function automatic directed_row_t load_row(int unsigned a, int unsigned b);
    directed_row_t r;
    r.func       = FUNC_LOAD;
    r.arrival    = a[PORT_TIME_W-1:0];
    r.burst      = b[PORT_TIME_W-1:0];
    r.typed      = 1'b0;
    r.typed_slot = '0;
    return r;
  endfunction

  // tick row; typed = 0 means the predictor supplies the expected beat
  function automatic directed_row_t tick_row(bit typed, slot_report_t s);
    directed_row_t r;
    r.func       = FUNC_TICK;
    r.arrival    = PORT_TIME_W'($urandom);
    r.burst      = PORT_TIME_W'($urandom);
    r.typed      = typed;
    r.typed_slot = s;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // mismatch reporting and result checking
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("mismatch %0d: %s got %0h expected %0h at %0t", err_count, what, got, want,
               $realtime);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) flag_mismatch(name, got, want);
  endtask

  // result side: check each accepted beat, then pick the next stall value
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_slots.size() == 0) begin
        flag_mismatch("result beat with nothing expected, slot_start", out_slot_start, 0);
      end else begin
        head_slot = pending_slots.pop_front();
        check_field("slot_start", out_slot_start, head_slot.slot_start);
        check_field("running_label", out_running_label, head_slot.label);
        check_field("finished", out_finished, head_slot.finished);
        check_field("completion_time", out_completion_time, head_slot.completion);
        check_field("turnaround", out_turnaround, head_slot.turnaround);
        check_field("waiting", out_waiting, head_slot.waiting);
        check_field("all_done", out_all_done, head_slot.all_done);
        if (head_slot.finished) finishes_seen++;
      end
    end
    // the stall pattern drifts against the tick
    case (stall_style)
      STALL_NONE:    out_stall <= 1'b0;
      STALL_RANDOM:  out_stall <= ($urandom_range(0, 99) < 35);
      STALL_PATTERN: out_stall <= ((stall_phase % 11) < 4);
      default:       out_stall <= 1'b0;
    endcase
    stall_phase++;
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  // drive one beat, hold it until taken, then update the predictor;
  // the sender runs in bursts with random gaps between them when gaps_on is set
  task automatic send_beat(input logic f, input logic [PORT_TIME_W-1:0] a,
                           input logic [PORT_TIME_W-1:0] b, input bit typed,
                           input slot_report_t typed_slot);
    slot_report_t predicted;
    bit           took;
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_valid        <= 1'b1;
    in_func         <= f;
    in_arrival_time <= a;
    in_burst_time   <= b;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) burst_left--;
    if (f == FUNC_TICK) begin
      predicted = run_slot();
      pending_slots.push_back(typed ? typed_slot : predicted);
      ticks_sent++;
    end else begin
      took = store_process(a, b);
      if (took) loads_taken++;
      else loads_dropped++;
    end
  endtask

  // hold the sender off until every expected beat has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_slots.size() != 0);
  endtask

  directed_row_t dir_rows[$];

  initial begin
    int          counted;
    int          pick_kind;
    bit          mid_drain_done;
    logic        f;
    logic [15:0] a;
    logic [15:0] b;

    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_func         <= FUNC_LOAD;
    in_arrival_time <= '0;
    in_burst_time   <= '0;
    proc_count      = 0;
    clock_now       = 0;
    foreach (done_tbl[i]) done_tbl[i] = 1'b0;

    // directed table: empty table, zero burst, single finish, all finished,
    // field extremes, remaining-time ties broken by arrival and then by label,
    // and a short job preempting a longer one
    dir_rows.push_back(tick_row(1, slot_of(0, 0, 0, 0, 0, 0, 1)));  // nothing loaded
    dir_rows.push_back(tick_row(1, slot_of(1, 0, 0, 0, 0, 0, 1)));
    dir_rows.push_back(load_row(5, 0));                              // zero burst, dropped
    dir_rows.push_back(tick_row(1, slot_of(2, 0, 0, 0, 0, 0, 1)));
    dir_rows.push_back(load_row(0, 1));                              // label 1
    dir_rows.push_back(tick_row(1, slot_of(3, 1, 1, 4, 4, 3, 1)));  // label 1 completes
    dir_rows.push_back(tick_row(1, slot_of(4, 0, 0, 0, 0, 0, 1)));  // all finished, idle
    dir_rows.push_back(load_row(16'hFFFF, 16'hFFFF));               // label 2, arrives at the end
    dir_rows.push_back(tick_row(1, slot_of(5, 0, 0, 0, 0, 0, 0)));
    dir_rows.push_back(load_row(6, 3));                              // label 3
    dir_rows.push_back(load_row(6, 3));                              // label 4, full tie with 3
    dir_rows.push_back(load_row(3, 3));                              // label 5, earlier arrival
    repeat (4) dir_rows.push_back(tick_row(0, '0));
    dir_rows.push_back(load_row(0, 1));                              // label 6, preempts
    repeat (7) dir_rows.push_back(tick_row(0, '0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    stall_style = STALL_PATTERN;
    foreach (dir_rows[i])
      send_beat(dir_rows[i].func, dir_rows[i].arrival, dir_rows[i].burst, dir_rows[i].typed,
                dir_rows[i].typed_slot);
    wait_drained();

    // random traffic: mostly ticks, loads arriving near the current time with
    // short bursts so jobs really compete, plus far-future arrivals, huge
    // bursts and zero bursts as noise; once the table is full loads are dropped
    counted        = 0;
    mid_drain_done = 1'b0;
    while (counted < RANDOM_BEATS) begin
      if (counted % 100 == 0) stall_style = stall_style_t'($urandom_range(0, 2));
      gaps_on = ((counted / 50) % 4 != 3);
      if (counted >= RANDOM_BEATS / 2 && !mid_drain_done) begin
        wait_drained();
        mid_drain_done = 1'b1;
      end
      pick_kind = $urandom_range(0, 99);
      f = FUNC_LOAD;
      a = 16'($urandom);
      b = 16'($urandom);
      if (pick_kind < 25) begin
        a = 16'(clip_to_time(longint'(clock_now) + $urandom_range(0, 12)));
        b = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 30)) : 16'($urandom_range(1, 6));
      end else if (pick_kind < 29) begin
        b = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 8)) : b;
      end else if (pick_kind < 33) begin
        b = '0;
      end else begin
        f = FUNC_TICK;
      end
      counted++;
      send_beat(f, a, b, 1'b0, '0);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_slots.size() != 0)
      flag_mismatch("expected beats never delivered", pending_slots.size(), 0);

    $display("run covered %0d ticks, %0d stored loads and %0d dropped loads",
             ticks_sent, loads_taken, loads_dropped);
    $display("%0d jobs completed, %0d mismatches", finishes_seen, err_count);
    if (err_count == 0) begin
      $display("[srtf_tick_scheduler_unit] OK");
    end else begin
      $display("[srtf_tick_scheduler_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> srtf_tick_scheduler_unit.f
design/srtf_pkg.sv
design/srtf_cell.sv
design/srtf_tick_scheduler_unit.sv
sim/tb_srtf_tick_scheduler_unit.sv
